// ===== src/stt_pkg.sv =====
// Package with types, codes and sizes shared by the sleep timer table.
package stt_pkg;

  localparam int TIMER_SLOTS = 32;
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
  localparam int TICK_W      = 64;
  localparam int PID_W       = 16;
  localparam int ACT_W       = 6;
  localparam int ENTRY_W     = TICK_W + PID_W;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_QUERY = 2'd1,
    OP_SLEEP = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_WAKE     = 2'd0,
    KIND_TICKS    = 2'd1,
    KIND_ACCEPTED = 2'd2,
    KIND_FULL     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    op_e               operation;
    logic [15:0]       tick_increment;
    logic [31:0]       sleep_duration;
    logic [PID_W-1:0]  requester;
  } cmd_t;

  typedef struct packed {
    kind_e             kind;
    logic [PID_W-1:0]  process_id;
    logic [TICK_W-1:0] tick_value;
    logic [ACT_W-1:0]  active_timers;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [TICK_W-1:0] deadline;
    logic [PID_W-1:0]  holder;
  } entry_t;

  typedef struct packed {
    logic    valid;
    result_t word;
  } emit_t;

endpackage

// ===== src/stt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/stt_ctrl.sv =====
// Command sequencer: tick count, busy bits, slot scan and sleep slot allocation.
module stt_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  stt_pkg::cmd_t               cmd_i,
  output logic                        busy,
  output logic                        ram_we_o,
  output logic [stt_pkg::SLOT_W-1:0]  ram_waddr_o,
  output stt_pkg::entry_t             ram_wdata_o,
  output logic                        ram_re_o,
  output logic [stt_pkg::SLOT_W-1:0]  ram_raddr_o,
  input  stt_pkg::entry_t             ram_rdata_i,
  output stt_pkg::emit_t              emit_o
);

  stt_pkg::state_e                   state_q, state_d;
  logic [stt_pkg::TICK_W-1:0]        tick_q, tick_d;
  logic [stt_pkg::ACT_W-1:0]         bcnt_q, bcnt_d;
  logic [stt_pkg::TIMER_SLOTS-1:0]   slot_busy_q, slot_busy_d;
  logic [stt_pkg::CNT_W-1:0]         rd_addr_q, rd_addr_d;
  logic                              cmp_vld_q, cmp_vld_d;
  logic [stt_pkg::SLOT_W-1:0]        cmp_idx_q, cmp_idx_d;
  logic                              pend_vld_q, pend_vld_d;
  logic [stt_pkg::PID_W-1:0]         pend_pid_q, pend_pid_d;
  logic [stt_pkg::ACT_W-1:0]         pend_cnt_q, pend_cnt_d;

  logic                              accept;
  logic                              issue;
  logic                              expired;
  logic                              scan_end;
  logic                              free_found;
  logic [stt_pkg::SLOT_W-1:0]        free_idx;

  assign busy     = (state_q != stt_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign issue    = (state_q == stt_pkg::ST_SCAN) &&
                    (rd_addr_q < stt_pkg::CNT_W'(stt_pkg::TIMER_SLOTS));
  assign expired  = cmp_vld_q && slot_busy_q[cmp_idx_q] &&
                    (tick_q >= ram_rdata_i.deadline);
  assign scan_end = cmp_vld_q &&
                    (cmp_idx_q == stt_pkg::SLOT_W'(stt_pkg::TIMER_SLOTS - 1));

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = stt_pkg::TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!slot_busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = stt_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      stt_pkg::ST_IDLE: begin
        if (accept && cmd_i.operation == stt_pkg::OP_TICK) begin
          state_d = stt_pkg::ST_SCAN;
        end
      end
      stt_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = stt_pkg::ST_FLUSH;
        end
      end
      stt_pkg::ST_FLUSH: begin
        state_d = stt_pkg::ST_IDLE;
      end
      default: begin
        state_d = stt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    tick_d      = tick_q;
    bcnt_d      = bcnt_q;
    slot_busy_d = slot_busy_q;
    rd_addr_d   = rd_addr_q;
    cmp_vld_d   = issue;
    cmp_idx_d   = rd_addr_q[stt_pkg::SLOT_W-1:0];
    pend_vld_d  = pend_vld_q;
    pend_pid_d  = pend_pid_q;
    pend_cnt_d  = pend_cnt_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = free_idx;
    ram_wdata_o.deadline = tick_q + stt_pkg::TICK_W'(cmd_i.sleep_duration);
    ram_wdata_o.holder   = cmd_i.requester;
    ram_re_o    = issue;
    ram_raddr_o = rd_addr_q[stt_pkg::SLOT_W-1:0];
    emit_o      = '0;

    case (state_q)
      stt_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd_i.operation)
            stt_pkg::OP_TICK: begin
              tick_d     = tick_q + stt_pkg::TICK_W'(cmd_i.tick_increment);
              rd_addr_d  = '0;
              pend_vld_d = 1'b0;
            end
            stt_pkg::OP_QUERY: begin
              emit_o.valid              = 1'b1;
              emit_o.word.kind          = stt_pkg::KIND_TICKS;
              emit_o.word.process_id    = cmd_i.requester;
              emit_o.word.tick_value    = tick_q;
              emit_o.word.active_timers = bcnt_q;
              emit_o.word.last          = 1'b1;
            end
            stt_pkg::OP_SLEEP: begin
              emit_o.valid           = 1'b1;
              emit_o.word.process_id = cmd_i.requester;
              emit_o.word.last       = 1'b1;
              if (free_found) begin
                ram_we_o                  = 1'b1;
                slot_busy_d[free_idx]     = 1'b1;
                bcnt_d                    = bcnt_q + 1'b1;
                emit_o.word.kind          = stt_pkg::KIND_ACCEPTED;
                emit_o.word.active_timers = bcnt_q + 1'b1;
              end else begin
                emit_o.word.kind          = stt_pkg::KIND_FULL;
                emit_o.word.active_timers = bcnt_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      stt_pkg::ST_SCAN: begin
        if (issue) begin
          rd_addr_d = rd_addr_q + 1'b1;
        end
        if (expired) begin
          slot_busy_d[cmp_idx_q] = 1'b0;
          bcnt_d                 = bcnt_q - 1'b1;
          // hand out the previous wake, hold the new one until its successor is known
          if (pend_vld_q) begin
            emit_o.valid              = 1'b1;
            emit_o.word.kind          = stt_pkg::KIND_WAKE;
            emit_o.word.process_id    = pend_pid_q;
            emit_o.word.active_timers = pend_cnt_q;
          end
          pend_vld_d = 1'b1;
          pend_pid_d = ram_rdata_i.holder;
          pend_cnt_d = bcnt_q - 1'b1;
        end
      end
      stt_pkg::ST_FLUSH: begin
        if (pend_vld_q) begin
          emit_o.valid              = 1'b1;
          emit_o.word.kind          = stt_pkg::KIND_WAKE;
          emit_o.word.process_id    = pend_pid_q;
          emit_o.word.active_timers = pend_cnt_q;
          emit_o.word.last          = 1'b1;
        end
        pend_vld_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stt_pkg::ST_IDLE;
      tick_q      <= '0;
      bcnt_q      <= '0;
      slot_busy_q <= '0;
      rd_addr_q   <= '0;
      cmp_vld_q   <= 1'b0;
      pend_vld_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      bcnt_q      <= bcnt_d;
      slot_busy_q <= slot_busy_d;
      rd_addr_q   <= rd_addr_d;
      cmp_vld_q   <= cmp_vld_d;
      pend_vld_q  <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    pend_pid_q <= pend_pid_d;
    pend_cnt_q <= pend_cnt_d;
  end

endmodule

// ===== src/sleep_timer_table.sv =====
// Top level of the sleep timer table: sequencer, slot memory and result register.
//
//   channel   handshake                    payload
//   command   start (in), busy (out)       cmd_i    : stt_pkg::cmd_t
//   result    result_valid_o (one cycle)   result_o : stt_pkg::result_t
//
// A command is taken at a rising edge with start high and busy low.
// Query and sleep answer in the next cycle and leave busy low.
// Tick advance holds busy through the scan: one slot memory read per cycle,
// each slot compared in the cycle after its read, then a flush state.
// Wake words leave at most one per cycle; the last one is flagged.
// Reset clears the count, busy bits and control state; slot memory is not cleared.
module sleep_timer_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  stt_pkg::cmd_t     cmd_i,
  output logic              busy,
  output logic              result_valid_o,
  output stt_pkg::result_t  result_o
);

  logic                       ram_we;
  logic [stt_pkg::SLOT_W-1:0] ram_waddr;
  stt_pkg::entry_t            ram_wdata;
  logic                       ram_re;
  logic [stt_pkg::SLOT_W-1:0] ram_raddr;
  stt_pkg::entry_t            ram_rdata;
  stt_pkg::emit_t             emit;
  logic                       valid_q;
  stt_pkg::result_t           result_q;

  stt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cmd_i       (cmd_i),
    .busy        (busy),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .emit_o      (emit)
  );

  stt_ram #(
    .WIDTH (stt_pkg::ENTRY_W),
    .DEPTH (stt_pkg::TIMER_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      result_q <= emit.word;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

// ===== src/stt_checker.sv =====
// Port-level checks for the sleep timer table, bound to the top level.
module stt_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input stt_pkg::cmd_t    cmd_i,
  input logic             busy,
  input logic             result_valid_o,
  input stt_pkg::result_t result_o
);

  a_only_wake_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.kind != stt_pkg::KIND_WAKE |-> result_o.last)
    else $error("non-wake word without last flag");

  a_ticks_only_on_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.kind != stt_pkg::KIND_TICKS |-> result_o.tick_value == '0)
    else $error("tick value set on a word that is not a count reply");

  a_query_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.operation == stt_pkg::OP_QUERY |=>
      result_valid_o && result_o.kind == stt_pkg::KIND_TICKS && result_o.last)
    else $error("query not answered in the next cycle");

  a_sleep_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.operation == stt_pkg::OP_SLEEP |=>
      result_valid_o && (result_o.kind == stt_pkg::KIND_ACCEPTED ||
                         result_o.kind == stt_pkg::KIND_FULL))
    else $error("sleep request not answered in the next cycle");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.kind == stt_pkg::KIND_FULL |->
      result_o.active_timers == stt_pkg::ACT_W'(stt_pkg::TIMER_SLOTS))
    else $error("table full with free slots counted");

endmodule

bind sleep_timer_table stt_checker u_stt_checker (.*);
